[hw/rtl/e2q_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
   localparam int CordicStagesDefault = 14;
   localparam int AtanEntries = 24;
   localparam int AngleLimit = 25736;
   localparam int QuatOne = 16384;
   localparam int CordicW = 33;
   localparam logic signed [CordicW-1:0] CordicGain = 33'sh026DD3B6A;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [CordicW-1:0] atan_entry(input int idx);
      logic signed [CordicW-1:0] r;
      begin
         case (idx)
            0: r = 33'sh03243F6A8;  1: r = 33'sh01DAC6705;
            2: r = 33'sh00FADBAFC;  3: r = 33'sh007F56EA6;
            4: r = 33'sh003FEAB76;  5: r = 33'sh001FFD55B;
            6: r = 33'sh000FFFAAA;  7: r = 33'sh0007FFF55;
            8: r = 33'sh0003FFFEA;  9: r = 33'sh0001FFFFD;
            10: r = 33'sh0000FFFFF; 11: r = 33'sh00007FFFF;
            12: r = 33'sh00003FFFF; 13: r = 33'sh00001FFFF;
            14: r = 33'sh00000FFFF; 15: r = 33'sh000007FFF;
            16: r = 33'sh000003FFF; 17: r = 33'sh000001FFF;
            18: r = 33'sh000000FFF; 19: r = 33'sh0000007FF;
            20: r = 33'sh0000003FF; 21: r = 33'sh0000001FF;
            22: r = 33'sh0000000FF; 23: r = 33'sh00000007F;
            default: r = '0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

[hw/rtl/euler_to_quaternion.sv]
// Pipeline: min(CORDIC_STAGES,24) CORDIC stages, 2 registers around them and 3 for
// the product tree.
// Throughput: one beat per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous) clears only the valid pipeline; data registers are unreset.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion #(
   parameter int CORDIC_STAGES = e2q_pkg::CordicStagesDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire e2q_pkg::req_type req_data,
   output logic               rsp_valid,
   output e2q_pkg::rsp_type   rsp_data
);
   import e2q_pkg::*;
   localparam int Run = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
   localparam int Lat = Run + 5;

   logic signed [17:0] cr, sr, cp, sp, cy, sy;
   logic [Lat-1:0] valid_ff;
   logic [Lat-1:0] valid_in;

   assign busy = 1'b0;

   e2q_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .angle(req_data.roll_angle), .cos_out(cr), .sin_out(sr));
   e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .angle(req_data.pitch_angle), .cos_out(cp), .sin_out(sp));
   e2q_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .angle(req_data.yaw_angle), .cos_out(cy), .sin_out(sy));

   e2q_combine u_combine (
      .clock(clock), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
      .rsp(rsp_data));

   // valid shift line follows the data
   assign valid_in = {valid_ff[Lat-2:0], start};
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end
   assign rsp_valid = valid_ff[Lat-1];
endmodule
`default_nettype wire

[hw/rtl/e2q_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// Produces rounded Q.16 half-angle cosine and sine.
module e2q_cordic #(
   parameter int STAGES = e2q_pkg::CordicStagesDefault
) (
   input  wire                       clock,
   input  wire signed [15:0]         angle,
   output logic signed [17:0]        cos_out,
   output logic signed [17:0]        sin_out
);
   import e2q_pkg::*;
   localparam int Run = (STAGES < AtanEntries) ? STAGES : AtanEntries;

   logic signed [CordicW-1:0] x_ff [Run+1];
   logic signed [CordicW-1:0] y_ff [Run+1];
   logic signed [CordicW-1:0] z_ff [Run+1];
   logic signed [15:0] sat_in;
   logic signed [CordicW-1:0] xr_in, yr_in;

   // clamp to +-pi and scale to Q.30 half-angle
   always_comb begin
      sat_in = angle;
      if (angle > 16'sd25736) sat_in = 16'sd25736;
      if (angle < -16'sd25736) sat_in = -16'sd25736;
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= CordicGain;
      y_ff[0] <= '0;
      z_ff[0] <= {{(CordicW-32){sat_in[15]}}, sat_in, 16'h0000};
   end

   for (genvar i = 0; i < Run; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (!z_ff[i][CordicW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_entry(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_entry(i);
         end
      end
   end

   // round Q.30 to Q.16
   assign xr_in = (x_ff[Run] + 33'sd8192) >>> 14;
   assign yr_in = (y_ff[Run] + 33'sd8192) >>> 14;
   always_ff @(posedge clock) begin
      cos_out <= xr_in[17:0];
      sin_out <= yr_in[17:0];
   end
endmodule
`default_nettype wire

[hw/rtl/e2q_combine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Triple products, sums, rounding and saturation.
module e2q_combine (
   input  wire                  clock,
   input  wire signed [17:0]    cr,
   input  wire signed [17:0]    sr,
   input  wire signed [17:0]    cp,
   input  wire signed [17:0]    sp,
   input  wire signed [17:0]    cy,
   input  wire signed [17:0]    sy,
   output e2q_pkg::rsp_type     rsp
);
   import e2q_pkg::*;

   logic signed [35:0] cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [17:0] cy_ff, sy_ff;
   logic signed [53:0] p_ff [8];
   logic signed [54:0] sum_in [4];
   logic signed [15:0] comp_in [4];
   logic signed [20:0] q;

   // stage 1: roll x pitch pairs
   always_ff @(posedge clock) begin
      cc_ff <= cr * cp;
      ss_ff <= sr * sp;
      sc_ff <= sr * cp;
      cs_ff <= cr * sp;
      cy_ff <= cy;
      sy_ff <= sy;
   end

   // stage 2: times yaw terms
   always_ff @(posedge clock) begin
      p_ff[0] <= cc_ff * cy_ff;  p_ff[1] <= ss_ff * sy_ff;
      p_ff[2] <= sc_ff * cy_ff;  p_ff[3] <= cs_ff * sy_ff;
      p_ff[4] <= cs_ff * cy_ff;  p_ff[5] <= sc_ff * sy_ff;
      p_ff[6] <= cc_ff * sy_ff;  p_ff[7] <= ss_ff * cy_ff;
   end

   // stage 3: combine, round, saturate
   always_comb begin
      sum_in[0] = 55'(p_ff[0]) + 55'(p_ff[1]);
      sum_in[1] = 55'(p_ff[2]) - 55'(p_ff[3]);
      sum_in[2] = 55'(p_ff[4]) + 55'(p_ff[5]);
      sum_in[3] = 55'(p_ff[6]) - 55'(p_ff[7]);
      for (int k = 0; k < 4; k++) begin
         q = 21'((sum_in[k] + 55'sh200000000) >>> 34);
         if (q > 21'sd16384) comp_in[k] = 16'sd16384;
         else if (q < -21'sd16384) comp_in[k] = -16'sd16384;
         else comp_in[k] = q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp.quat_w <= comp_in[0];
      rsp.quat_x <= comp_in[1];
      rsp.quat_y <= comp_in[2];
      rsp.quat_z <= comp_in[3];
   end
endmodule
`default_nettype wire

[hw/rtl/e2q_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module e2q_checker (
   input wire               clock,
   input wire               reset,
   input wire               busy,
   input wire               rsp_valid,
   input wire e2q_pkg::rsp_type rsp_data
);
   // never refuses a beat
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   // result components w and z stay within unit range
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_w <= 16'sd16384 && rsp_data.quat_w >= -16'sd16384))
      else $error("quat_w out of range");
   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_z <= 16'sd16384 && rsp_data.quat_z >= -16'sd16384))
      else $error("quat_z out of range");
   // no result right after reset
   a_reset: assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire

[sim/tb_euler_to_quaternion.sv]
`timescale 1ns / 1ps
module tb_euler_to_quaternion;
   import e2q_pkg::*;

   localparam int Stages = CordicStagesDefault;
   localparam int LatencyCycles = Stages + 5;
   localparam int CycleLimit = 200000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   euler_to_quaternion #(.CORDIC_STAGES(Stages)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   req_type pending_angles[$];
   rsp_type expected_quats[$];
   int mismatch_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   int accepted_count = 0;
   bit stim_done = 0;
   bit quiet_stretch = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // floor shift on a signed 64-bit value
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   // half-angle cos/sin in Q.16 via rotation-mode CORDIC
   function automatic void half_trig(logic signed [15:0] ang, output longint c,
                                     output longint s);
      longint a, x, y, z, dx, dy, at;
      int n;
      a = ang;
      if (a > AngleLimit) a = AngleLimit;
      if (a < -AngleLimit) a = -AngleLimit;
      x = longint'(CordicGain);
      y = 0;
      z = a * 65536;
      n = (Stages < AtanEntries) ? Stages : AtanEntries;
      for (int i = 0; i < n; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         at = longint'(atan_entry(i));
         if (z >= 0) begin
            x -= dx; y += dy; z -= at;
         end else begin
            x += dx; y -= dy; z += at;
         end
      end
      c = fshift(x + 8192, 14);
      s = fshift(y + 8192, 14);
   endfunction

   function automatic logic signed [15:0] round_sat(longint sum48);
      longint q;
      q = fshift(sum48 + (longint'(1) << 33), 34);
      if (q > QuatOne) q = QuatOne;
      if (q < -QuatOne) q = -QuatOne;
      return q[15:0];
   endfunction

   function automatic rsp_type quat_of(req_type r);
      longint cr, sr, cp, sp, cy, sy;
      rsp_type q;
      half_trig(r.roll_angle, cr, sr);
      half_trig(r.pitch_angle, cp, sp);
      half_trig(r.yaw_angle, cy, sy);
      q.quat_w = round_sat(cr * cp * cy + sr * sp * sy);
      q.quat_x = round_sat(sr * cp * cy - cr * sp * sy);
      q.quat_y = round_sat(cr * sp * cy + sr * cp * sy);
      q.quat_z = round_sat(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want,
               checked_count);
      mismatch_count++;
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 200) + 25636) * ($urandom_range(0, 1) ? 1 : -1);
         default: return 16'($signed($urandom_range(0, 51472)) - 25736);
      endcase
   endfunction

   function automatic req_type mk(int r, int p, int y);
      req_type t;
      t.roll_angle = 16'(r);
      t.pitch_angle = 16'(p);
      t.yaw_angle = 16'(y);
      return t;
   endfunction

   // stimulus: directed corners, then random triples
   initial begin
      int corners[9];
      req_type t;
      corners = '{0, 1, -1, 25736, -25736, 25737, -25737, 32767, -32768};
      foreach (corners[k]) pending_angles.push_back(mk(corners[k], 0, 0));
      foreach (corners[k]) pending_angles.push_back(mk(0, corners[k], corners[8 - k]));
      pending_angles.push_back(mk(12868, 12868, 12868));
      pending_angles.push_back(mk(-12868, 25736, -25736));
      pending_angles.push_back(mk(16'h5555, 16'hAAAA, 16'h7FFF));
      pending_angles.push_back(mk(16'hAAAA, 16'h5555, 16'h8000));
      for (int n = 0; n < 1900; n++) begin
         t.roll_angle = rand_angle();
         t.pitch_angle = rand_angle();
         t.yaw_angle = rand_angle();
         pending_angles.push_back(t);
      end
   end

   // driver
   always @(posedge clock) begin
      bit go;
      cycle_count <= cycle_count + 1;
      if (cycle_count < 12) begin
         reset <= 1'b1;
         start <= 1'b0;
         req_data <= '0;
      end else begin
         reset <= 1'b0;
         if (start && !busy) begin
            expected_quats.push_back(quat_of(req_data));
            accepted_count <= accepted_count + 1;
            void'(pending_angles.pop_front());
         end
         quiet_stretch <= (cycle_count % 1000) > 600;
         go = quiet_stretch || ($urandom_range(0, 99) >= 10);
         if (start && busy) begin
            start <= 1'b1;
         end else if ((pending_angles.size() > 0) && go) begin
            start <= 1'b1;
            req_data <= pending_angles[0];
         end else begin
            start <= 1'b0;
            req_data <= req_type'({$urandom, $urandom});
            if (pending_angles.size() == 0 && cycle_count > 20)
               stim_done <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = expected_quats.pop_front();
            if (rsp_data.quat_w !== want.quat_w)
               report_mismatch("quat_w", rsp_data.quat_w, want.quat_w);
            if (rsp_data.quat_x !== want.quat_x)
               report_mismatch("quat_x", rsp_data.quat_x, want.quat_x);
            if (rsp_data.quat_y !== want.quat_y)
               report_mismatch("quat_y", rsp_data.quat_y, want.quat_y);
            if (rsp_data.quat_z !== want.quat_z)
               report_mismatch("quat_z", rsp_data.quat_z, want.quat_z);
            checked_count++;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && expected_quats.size() == 0 || cycle_count >= CycleLimit);
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
      repeat (LatencyCycles * 2) @(posedge clock);
      $display("covered %0d angle triples (corners, saturation, random), %0d beats checked",
               accepted_count, checked_count);
      if (mismatch_count == 0 && expected_quats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d beats left", mismatch_count, expected_quats.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
